@@ hw/rtl/encoder_wrap_unwrap_position_top_assert.svh @@
// Assertion macros for the encoder unwrap block.
`ifndef ENCODER_WRAP_UNWRAP_POSITION_TOP_ASSERT_SVH
`define ENCODER_WRAP_UNWRAP_POSITION_TOP_ASSERT_SVH

// same-cycle implication
`define EPU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define EPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/epu_pkg.sv @@
package epu_pkg;

	localparam longint PULSES_PER_REV = 4000;
	localparam longint COUNT_LIMIT    = 64000;
	localparam longint SCREW_PITCH_MM = 5;
	localparam longint QUM_PER_MM     = 4000;

	localparam int COUNT_W = 16;
	localparam int WRAP_W  = 16;
	localparam int POS_W   = 35;
	localparam int OUT_W   = 36;
	localparam int X_W     = 32;
	localparam int FINT_W  = 36;
	localparam int SUM_W   = 56;
	localparam int PROD_W  = 65;
	localparam int DELTA_W = 18;

	// quarter-micrometers per pulse, split into integer and remainder parts
	localparam longint PULSE_SCALE = SCREW_PITCH_MM * QUM_PER_MM;
	localparam longint FRAC_INT    = PULSE_SCALE / PULSES_PER_REV;
	localparam longint FRAC_REM    = PULSE_SCALE % PULSES_PER_REV;
	localparam longint WRAP_SCALE  = (COUNT_LIMIT / PULSES_PER_REV) * PULSE_SCALE;

	// exact floor(x / PULSES_PER_REV) for x < 2**32
	localparam int     RECIP_SH = X_W + $clog2(PULSES_PER_REV);
	localparam longint RECIP    = ((64'sd1 <<< RECIP_SH) + PULSES_PER_REV - 1) / PULSES_PER_REV;

	localparam logic signed [DELTA_W-1:0] HALF_LIMIT = DELTA_W'(COUNT_LIMIT / 2);
	localparam logic [X_W-1:0]            FRAC_REM_V = X_W'(FRAC_REM);
	localparam logic [FINT_W-1:0]         FRAC_INT_V = FINT_W'(FRAC_INT);
	localparam logic signed [SUM_W-1:0]   WRAP_SCALE_V = SUM_W'(WRAP_SCALE);
	localparam logic [PROD_W-1:0]         RECIP_V = PROD_W'(RECIP);

	localparam logic signed [SUM_W-1:0] SUM_POS_MAX = SUM_W'(64'sd17179869183);
	localparam logic signed [SUM_W-1:0] SUM_POS_MIN = SUM_W'(-64'sd17179869184);
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	localparam logic signed [WRAP_W-1:0] WRAP_MAX = {1'b0, {(WRAP_W-1){1'b1}}};
	localparam logic signed [WRAP_W-1:0] WRAP_MIN = {1'b1, {(WRAP_W-1){1'b0}}};

	localparam logic OP_SAMPLE   = 1'b0;
	localparam logic OP_SET_ZERO = 1'b1;

	typedef struct packed {
		logic op;
		logic emit;
	} epu_ctl_t;

endpackage

@@ hw/rtl/epu_track.sv @@
module epu_track (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic [epu_pkg::COUNT_W-1:0]          count,
	output logic signed [epu_pkg::WRAP_W-1:0]    wrap,
	output logic signed [epu_pkg::WRAP_W-1:0]    wrap_next,
	output logic                                 delta_nz
);

	logic [epu_pkg::COUNT_W-1:0]         last_count_q;
	logic signed [epu_pkg::WRAP_W-1:0]   wrap_q;
	logic signed [epu_pkg::DELTA_W-1:0]  delta;
	logic                                jump_up;
	logic                                jump_dn;

	assign delta = $signed({2'b00, count}) - $signed({2'b00, last_count_q});
	assign jump_dn = delta > epu_pkg::HALF_LIMIT;
	assign jump_up = delta < -epu_pkg::HALF_LIMIT;
	assign delta_nz = delta != '0;
	assign wrap = wrap_q;

	always_comb begin
		wrap_next = wrap_q;
		if (jump_dn && wrap_q != epu_pkg::WRAP_MIN) begin
			wrap_next = wrap_q - 16'sd1;
		end else if (jump_up && wrap_q != epu_pkg::WRAP_MAX) begin
			wrap_next = wrap_q + 16'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
			wrap_q       <= '0;
		end else if (step) begin
			last_count_q <= count;
			wrap_q       <= wrap_next;
		end
	end

endmodule

@@ hw/rtl/epu_scale.sv @@
module epu_scale (
	input  logic                                 clk,
	input  logic                                 en_s3,
	input  logic                                 en_s4,
	input  logic signed [epu_pkg::WRAP_W-1:0]    wrap_s2,
	input  logic [epu_pkg::X_W-1:0]              x_s2,
	input  logic [epu_pkg::FINT_W-1:0]           fint_s2,
	output logic signed [epu_pkg::POS_W-1:0]     cur_s4
);

	logic signed [epu_pkg::SUM_W-1:0]  wt_c;
	logic [epu_pkg::PROD_W-1:0]        prod_c;
	logic signed [epu_pkg::SUM_W-1:0]  wt_s3;
	logic [epu_pkg::FINT_W-1:0]        fint_s3;
	logic [epu_pkg::COUNT_W-1:0]       q_s3;
	logic signed [epu_pkg::SUM_W-1:0]  sum_c;
	logic signed [epu_pkg::POS_W-1:0]  cur_c;

	assign wt_c   = epu_pkg::SUM_W'(wrap_s2) * epu_pkg::WRAP_SCALE_V;
	assign prod_c = epu_pkg::PROD_W'(x_s2) * epu_pkg::RECIP_V;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			wt_s3   <= wt_c;
			fint_s3 <= fint_s2;
			q_s3    <= prod_c[epu_pkg::RECIP_SH +: epu_pkg::COUNT_W];
		end
	end

	assign sum_c = wt_s3 + $signed({{(epu_pkg::SUM_W-epu_pkg::FINT_W){1'b0}}, fint_s3})
		+ $signed({{(epu_pkg::SUM_W-epu_pkg::COUNT_W){1'b0}}, q_s3});

	always_comb begin
		if (sum_c > epu_pkg::SUM_POS_MAX) begin
			cur_c = epu_pkg::POS_MAX;
		end else if (sum_c < epu_pkg::SUM_POS_MIN) begin
			cur_c = epu_pkg::POS_MIN;
		end else begin
			cur_c = sum_c[epu_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cur_s4 <= cur_c;
		end
	end

endmodule

@@ hw/rtl/encoder_wrap_unwrap_position_top.sv @@
// channel   signals                                   handshake
// sample    op, raw_count, parse_ok                   sample_valid / sample_ready
// result    position                                  result_valid / result_ready
//
// One item per cycle sustained while results are taken without stall.
// Path: input register, wrap tracker, multiply stage, saturating sum, offset/output register.
// Reset clears wrap count, last count, current position (cur_q) and zero offset at once.
// Empty stages fill while a result waits; input stalls only when every stage is full.
`include "encoder_wrap_unwrap_position_top_assert.svh"

module encoder_wrap_unwrap_position_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic                                 op,
	input  logic [epu_pkg::COUNT_W-1:0]          raw_count,
	input  logic                                 parse_ok,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [epu_pkg::OUT_W-1:0]     position
);

	logic                                v_s1, v_s2, v_s3, v_s4;
	logic                                en_s1, en_s2, en_s3, en_s4, en_out;
	logic                                op_s1, ok_s1;
	logic [epu_pkg::COUNT_W-1:0]         count_s1;
	epu_pkg::epu_ctl_t                   ctl_c, ctl_s2, ctl_s3, ctl_s4;
	logic                                step;
	logic                                leave_s4;
	logic signed [epu_pkg::WRAP_W-1:0]   wrap;
	logic signed [epu_pkg::WRAP_W-1:0]   wrap_next;
	logic                                delta_nz;
	logic signed [epu_pkg::WRAP_W-1:0]   wrap_s2;
	logic [epu_pkg::X_W-1:0]             x_s2;
	logic [epu_pkg::FINT_W-1:0]          fint_s2;
	logic signed [epu_pkg::POS_W-1:0]    cur_s4;
	logic signed [epu_pkg::POS_W-1:0]    cur_q;
	logic signed [epu_pkg::POS_W-1:0]    zero_offset_q;

	assign en_out = !result_valid || result_ready;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign sample_ready = en_s1;

	assign step     = v_s1 && en_s2 && op_s1 == epu_pkg::OP_SAMPLE;
	assign leave_s4 = v_s4 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1    <= op;
			ok_s1    <= parse_ok;
			count_s1 <= parse_ok ? raw_count : '0;
		end
	end

	epu_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.count     (count_s1),
		.wrap      (wrap),
		.wrap_next (wrap_next),
		.delta_nz  (delta_nz)
	);

	always_comb begin
		ctl_c.op   = op_s1;
		ctl_c.emit = op_s1 == epu_pkg::OP_SAMPLE && ok_s1 && delta_nz;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2  <= ctl_c;
			wrap_s2 <= wrap_next;
			x_s2    <= epu_pkg::X_W'(count_s1) * epu_pkg::FRAC_REM_V;
			fint_s2 <= epu_pkg::FINT_W'(count_s1) * epu_pkg::FRAC_INT_V;
		end
		if (en_s3) ctl_s3 <= ctl_s2;
		if (en_s4) ctl_s4 <= ctl_s3;
	end

	epu_scale u_scale (
		.clk     (clk),
		.en_s3   (en_s3),
		.en_s4   (en_s4),
		.wrap_s2 (wrap_s2),
		.x_s2    (x_s2),
		.fint_s2 (fint_s2),
		.cur_s4  (cur_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= '0;
			zero_offset_q <= '0;
			result_valid  <= 1'b0;
		end else begin
			if (result_valid && result_ready) result_valid <= 1'b0;
			if (leave_s4) begin
				if (ctl_s4.op == epu_pkg::OP_SET_ZERO) begin
					zero_offset_q <= (cur_q == epu_pkg::POS_MIN) ? epu_pkg::POS_MAX : -cur_q;
				end else begin
					cur_q <= cur_s4;
				end
				if (ctl_s4.emit) result_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s4 && ctl_s4.emit) begin
			position <= epu_pkg::OUT_W'(zero_offset_q) + epu_pkg::OUT_W'(cur_s4);
		end
	end

	`EPU_ASSERT_NEXT(a_emit_shows, leave_s4 && ctl_s4.emit, result_valid)
	`EPU_ASSERT_NOW(a_stall_full, v_s2 && !en_s2, v_s3 && v_s4 && result_valid && !result_ready)
	`EPU_ASSERT_NEXT(a_wrap_step, step,
		wrap == $past(wrap) || wrap == $past(wrap) + 16'sd1 || wrap == $past(wrap) - 16'sd1)

endmodule

@@ tb/tb_encoder_wrap_unwrap_position_top.sv @@
module tb_encoder_wrap_unwrap_position_top;

	localparam longint QUM_PER_MM = 4000;
	localparam longint POS35_MAX = 64'sd17179869183;
	localparam longint POS35_MIN = -64'sd17179869184;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED = 24;

	typedef struct packed {
		logic o;
		logic [15:0] rc;
		logic ok;
		logic typed;
		logic signed [35:0] val;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic op = epu_pkg::OP_SAMPLE;
	logic [15:0] raw_count = '0;
	logic parse_ok = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [35:0] position;

	encoder_wrap_unwrap_position_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.op(op),
		.raw_count(raw_count),
		.parse_ok(parse_ok),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.position(position)
	);

	always #2 clk = ~clk;

	// position tracker state
	logic [15:0] last_cnt = '0;
	int wraps = 0;
	longint cur_pos = 0;
	longint zero_ofs = 0;
	int wrap_lo = 0;
	int wrap_hi = 0;

	logic signed [35:0] pending_positions[$];
	logic signed [35:0] want_pos;
	int send_pct = 20;
	int recv_pct = 20;
	int stall_left = 0;
	int idle_cycles = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_zero_sets = 0;
	int n_fail = 0;

	stim_row_t dir_rows [0:N_DIRECTED-1] = '{
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd1,     1'b1, 1'b1, 36'sd5},
		'{epu_pkg::OP_SAMPLE,   16'd65535, 1'b1, 1'b1, 36'sd7675},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b1, 1'b1, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd32000, 1'b1, 1'b1, 36'sd160000},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b1, 1'b1, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd32001, 1'b1, 1'b1, -36'sd159995},
		'{epu_pkg::OP_SAMPLE,   16'd1,     1'b1, 1'b1, -36'sd319995},
		'{epu_pkg::OP_SAMPLE,   16'd1,     1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd63999, 1'b1, 1'b1, -36'sd320005},
		'{epu_pkg::OP_SAMPLE,   16'd64000, 1'b1, 1'b1, -36'sd320000},
		'{epu_pkg::OP_SAMPLE,   16'd40000, 1'b0, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SET_ZERO, 16'd12345, 1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd4,     1'b1, 1'b1, 36'sd20},
		'{epu_pkg::OP_SET_ZERO, 16'd65535, 1'b0, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b0, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd33000, 1'b1, 1'b1, -36'sd155020},
		'{epu_pkg::OP_SAMPLE,   16'd1000,  1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd65535, 1'b1, 1'b0, 36'sd0},
		'{epu_pkg::OP_SET_ZERO, 16'd0,     1'b0, 1'b0, 36'sd0},
		'{epu_pkg::OP_SAMPLE,   16'd65534, 1'b1, 1'b1, -36'sd5},
		'{epu_pkg::OP_SAMPLE,   16'd0,     1'b0, 1'b0, 36'sd0}
	};

	function automatic longint clamp35(input longint v);
		if (v > POS35_MAX)
			return POS35_MAX;
		if (v < POS35_MIN)
			return POS35_MIN;
		return v;
	endfunction

	// updates tracker state; returns 1 when the sample yields a position
	function automatic bit predict_position(input logic o, input logic [15:0] rc,
			input logic ok, output logic signed [35:0] pos);
		longint cnt;
		longint delta;
		longint half;
		longint wrap_term;
		longint frac_term;
		pos = '0;
		if (o == epu_pkg::OP_SET_ZERO) begin
			zero_ofs = clamp35(-cur_pos);
			n_zero_sets++;
			return 1'b0;
		end
		cnt = ok ? longint'(rc) : 64'sd0;
		delta = cnt - longint'(last_cnt);
		half = epu_pkg::COUNT_LIMIT / 2;
		if (delta > half && wraps > -32768)
			wraps--;
		if (delta < -half && wraps < 32767)
			wraps++;
		if (wraps < wrap_lo)
			wrap_lo = wraps;
		if (wraps > wrap_hi)
			wrap_hi = wraps;
		last_cnt = cnt[15:0];
		wrap_term = longint'(wraps) * (epu_pkg::COUNT_LIMIT / epu_pkg::PULSES_PER_REV)
			* epu_pkg::SCREW_PITCH_MM * QUM_PER_MM;
		frac_term = cnt * epu_pkg::SCREW_PITCH_MM * QUM_PER_MM / epu_pkg::PULSES_PER_REV;
		cur_pos = clamp35(wrap_term + frac_term);
		pos = 36'(zero_ofs + cur_pos);
		return (delta != 0) && ok;
	endfunction

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 25;
			default: return 60;
		endcase
	endfunction

	function automatic logic [15:0] pick_count();
		int k;
		int c;
		int sgn;
		int mag;
		k = $urandom_range(99);
		if (k < 40) begin
			c = (int'(last_cnt) + 64000 + $urandom_range(0, 4000) - 2000) % 64000;
		end else if (k < 55) begin
			sgn = $urandom_range(1) ? 1 : -1;
			mag = 32000 + $urandom_range(0, 6) - 3;
			c = int'(last_cnt) + sgn * mag;
			if (c > 65535 || c < 0)
				c = int'(last_cnt) - sgn * mag;
			if (c < 0)
				c = 0;
			if (c > 65535)
				c = 65535;
		end else if (k < 70) begin
			c = $urandom_range(0, 65535);
		end else if (k < 80) begin
			case ($urandom_range(6))
				0: c = 0;
				1: c = 1;
				2: c = 63999;
				3: c = 64000;
				4: c = 65535;
				5: c = 32000;
				default: c = 32001;
			endcase
		end else if (k < 90) begin
			c = int'(last_cnt);
		end else begin
			c = $urandom_range(0, 63999);
		end
		return 16'(c);
	endfunction

	task automatic send_item(input logic o, input logic [15:0] rc, input logic ok,
			input logic typed, input logic signed [35:0] typed_pos);
		int gap;
		logic signed [35:0] p;
		bit hit;
		gap = pick_gap(send_pct);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		op <= o;
		raw_count <= rc;
		parse_ok <= ok;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		hit = predict_position(o, rc, ok, p);
		if (typed)
			pending_positions.push_back(typed_pos);
		else if (hit)
			pending_positions.push_back(p);
		n_items++;
	endtask

	task automatic random_items(input int n);
		int i;
		logic o;
		logic ok;
		for (i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				send_pct = pick_pct();
				recv_pct = pick_pct();
			end
			o = ($urandom_range(99) < 5) ? epu_pkg::OP_SET_ZERO : epu_pkg::OP_SAMPLE;
			ok = ($urandom_range(99) >= 7);
			send_item(o, pick_count(), ok, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_positions.size() == 0) begin
				if (n_fail < 10)
					$display("unexpected position %0d", position);
				n_fail++;
			end else begin
				want_pos = pending_positions.pop_front();
				if (position !== want_pos) begin
					if (n_fail < 10)
						$display("position mismatch: expected %0d, got %0d", want_pos, position);
					n_fail++;
				end
				n_checked++;
			end
		end
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= pick_gap(recv_pct);
			result_ready <= 1'b1;
		end
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_DIRECTED; i++)
			send_item(dir_rows[i].o, dir_rows[i].rc, dir_rows[i].ok,
				dir_rows[i].typed, dir_rows[i].val);
		random_items(700);
		random_items(250);
		sample_valid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		$display("%0d items sent, %0d positions checked, %0d zero sets",
			n_items, n_checked, n_zero_sets);
		$display("wrap counter ranged from %0d to %0d", wrap_lo, wrap_hi);
		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/epu_pkg.sv
hw/rtl/epu_track.sv
hw/rtl/epu_scale.sv
hw/rtl/encoder_wrap_unwrap_position_top.sv
tb/tb_encoder_wrap_unwrap_position_top.sv
